// ===== src/bia_pkg.sv =====
package bia_pkg;

    localparam int CNT_W = 11;
    localparam int RID_W = 10;

    typedef enum logic
    {
        ST_IDLE,
        ST_MOD
    } st_t;

    typedef enum logic
    {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } act_t;

endpackage

// ===== src/bitmap_id_allocator.sv =====
// result: an allocation's result word is registered in ST_MOD when out_ready allows;
//   no request is taken in ST_MOD; each is one read and at most one write-back of a
//   bitmap word, for allocations picked by a summary register of nonempty words
// reset: all ids free, full flag clear, id_count 1024; no clearing pass, words never
//   written read as all free through per-word valid bits
module bitmap_id_allocator #(
    parameter int MAX_IDS   = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [bia_pkg::RID_W-1:0]  release_id,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       granted,
    output logic [bia_pkg::RID_W-1:0]  granted_id,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bia_pkg::CNT_W-1:0]  id_count
);

    import bia_pkg::*;

    localparam int NWORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int IW     = AW + BW;
    localparam int CMPW   = ((IW > CNT_W) ? IW : CNT_W) + 1;
    localparam int DW     = (IW > RID_W) ? IW : RID_W;
    localparam int SH     = 20;
    localparam int PW     = RID_W + SH + 1;
    localparam int RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;

    logic [WORD_BITS-1:0] mem [NWORDS];

    st_t                  state_reg, state_next;
    logic                 act_reg;
    logic [RID_W-1:0]     rid_reg;
    logic [AW-1:0]        addr_reg;
    logic                 found_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic                 full_reg, full_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NWORDS-1:0]    sum_reg, sum_next;
    logic [NWORDS-1:0]    vld_reg, vld_next;
    logic                 ov_reg, ov_next;
    logic                 og_reg;
    logic [RID_W-1:0]     oid_reg;

    logic                 accept;
    logic [AW-1:0]        enc_idx;
    logic                 enc_hit;
    logic [PW-1:0]        prod;
    logic [RID_W:0]       rel_q;
    logic [AW-1:0]        rel_addr;
    logic [AW-1:0]        addr_sel;
    logic [CNT_W-1:0]     cnt_eff;
    logic [IW-1:0]        base;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic [BW-1:0]        bit_idx;
    logic                 bit_hit;
    logic [DW-1:0]        rel_diff;
    logic [BW-1:0]        rel_bit;
    logic                 rel_ok;
    logic                 alloc_ok;
    logic                 can_out;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic [DW-1:0]        id_sum;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = ov_reg;
    assign granted    = og_reg;
    assign granted_id = oid_reg;

    assign cnt_eff = (32'(cnt_reg) > MAX_IDS) ? CNT_W'(MAX_IDS) : cnt_reg;

    // lowest word holding any free mark
    always_comb
    begin
        enc_idx = '0;
        enc_hit = 1'b0;
        for (int i = NWORDS - 1; i >= 0; i--)
        begin
            if (sum_reg[i])
            begin
                enc_idx = AW'(i);
                enc_hit = 1'b1;
            end
        end
    end

    // word index of the released id by reciprocal multiply
    assign prod     = PW'(release_id) * PW'(RECIP);
    assign rel_q    = prod[PW-1:SH];
    assign rel_addr = (32'(rel_q) < NWORDS) ? AW'(rel_q) : '0;
    assign addr_sel = (act_t'(action) == ACT_RELEASE) ? rel_addr : enc_idx;

    // modify stage
    assign word = rd_vld_reg ? rd_data_reg : '1;
    assign base = IW'(addr_reg) * IW'(WORD_BITS);

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[i] = (CMPW'(base) + CMPW'(i)) < CMPW'(cnt_eff);
        end
    end

    assign masked = word & mask;

    always_comb
    begin
        bit_idx = '0;
        bit_hit = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                bit_idx = BW'(i);
                bit_hit = 1'b1;
            end
        end
    end

    assign rel_diff = DW'(rid_reg) - DW'(base);
    assign rel_bit  = rel_diff[BW-1:0];
    assign rel_ok   = CMPW'(rid_reg) < CMPW'(cnt_eff);
    assign alloc_ok = !full_reg && found_reg && bit_hit;
    assign can_out  = !ov_reg || out_ready;
    assign id_sum   = DW'(base) + DW'(bit_idx);

    always_comb
    begin
        state_next = state_reg;
        full_next  = full_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        vld_next   = vld_reg;
        ov_next    = ov_reg && !out_ready;
        we         = 1'b0;
        wdata      = word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (act_t'(act_reg) == ACT_RELEASE)
                begin
                    state_next = ST_IDLE;
                    if (rel_ok)
                    begin
                        we        = 1'b1;
                        wdata     = word | (WORD_BITS'(1) << rel_bit);
                        full_next = 1'b0;
                    end
                end
                else if (can_out)
                begin
                    state_next = ST_IDLE;
                    ov_next    = 1'b1;
                    if (alloc_ok)
                    begin
                        we    = 1'b1;
                        wdata = word & ~(WORD_BITS'(1) << bit_idx);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (we)
        begin
            sum_next[addr_reg] = |wdata;
            vld_next[addr_reg] = 1'b1;
        end

        if (cfg_valid && cfg_ready)
        begin
            cnt_next  = id_count;
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            full_reg  <= 1'b0;
            cnt_reg   <= CNT_W'(1024);
            sum_reg   <= '1;
            vld_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            vld_reg   <= vld_next;
            ov_reg    <= ov_next;
        end
    end

    // request capture and bitmap memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr_reg] <= wdata;
        end
        if (accept)
        begin
            rd_data_reg <= mem[addr_sel];
            rd_vld_reg  <= vld_reg[addr_sel];
            act_reg     <= action;
            rid_reg     <= release_id;
            addr_reg    <= addr_sel;
            found_reg   <= enc_hit;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MOD && act_t'(act_reg) == ACT_ALLOC && can_out)
        begin
            og_reg  <= alloc_ok;
            oid_reg <= alloc_ok ? id_sum[RID_W-1:0] : '0;
        end
    end

endmodule
